>>> sv/magic_length_packet_deframer_assert.svh
// Assertion macros used by the deframer top level.
`ifndef MAGIC_LENGTH_PACKET_DEFRAMER_ASSERT_SVH
`define MAGIC_LENGTH_PACKET_DEFRAMER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define MLPD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define MLPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

>>> sv/mlpd_pkg.sv
// Types and constants of the magic-word length-prefixed deframer.
package mlpd_pkg;

  localparam int unsigned MagicW   = 64;
  localparam int unsigned LenW     = 32;
  localparam int unsigned LeftW    = LenW + 1;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CntW     = 5;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  localparam logic [CntW-1:0] MagicEnd  = CntW'(7);
  localparam logic [CntW-1:0] HlenEnd   = CntW'(15);
  localparam logic [CntW-1:0] PrefixEnd = CntW'(23);

  localparam logic [LenW-1:0] HeaderLimitRst = LenW'(32'd65535);
  localparam logic [LenW-1:0] BodyLimitRst   = LenW'(32'd16777215);

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_MAGIC  = 2'd0,
    REG_HEADER_LIMIT = 2'd1,
    REG_BODY_LIMIT   = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_START    = 2'd0,
    KIND_DATA     = 2'd1,
    KIND_BADMAGIC = 2'd2,
    KIND_TOOBIG   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HLEN = 2'd1,
    PH_BLEN = 2'd2,
    PH_DATA = 2'd3
  } phase_e;

  typedef struct packed {
    logic [MagicW-1:0] frame_magic;
    logic [LenW-1:0]   header_limit;
    logic [LenW-1:0]   body_limit;
  } cfg_t;

  typedef struct packed {
    kind_e            kind;
    logic [LenW-1:0]  header_len;
    logic [LenW-1:0]  body_len;
    logic [ByteW-1:0] data_byte;
    logic             last;
  } res_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [QCntW-1:0] count;
  } q_stat_t;

endpackage

>>> sv/mlpd_fifo.sv
// Short result queue between the parser and the result ports.
module mlpd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  mlpd_pkg::res_t wr_data_i,
  input  logic           rd_i,
  output mlpd_pkg::res_t rd_data_o,
  output mlpd_pkg::q_stat_t stat_o
);
  import mlpd_pkg::*;

  res_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.count = cnt_q;

  assign do_wr = wr_i && !stat_o.full;
  assign do_rd = rd_i && !stat_o.empty;

  always_comb begin
    wr_ptr_d = do_wr ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_rd ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assign rd_data_o = mem_q[rd_ptr_q];

endmodule

>>> sv/mlpd_front.sv
// Byte parser: hunts for the magic word, gathers both lengths, classifies bytes.
module mlpd_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mlpd_pkg::cfg_t               cfg_i,
  input  logic                         take_i,
  input  logic [mlpd_pkg::ByteW-1:0]   rx_byte_i,
  output logic                         res_vld_o,
  output mlpd_pkg::res_t               res_o,
  output mlpd_pkg::phase_e             phase_o
);
  import mlpd_pkg::*;

  phase_e           phase_q, phase_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             bad_q, bad_d;
  logic             hl_hi_q, hl_hi_d;
  logic             bl_hi_q, bl_hi_d;
  logic [LenW-1:0]  hl_q, hl_d;
  logic [LenW-1:0]  bl_q, bl_d;
  logic [LeftW-1:0] left_q, left_d;

  logic [2:0]       pos;
  logic [ByteW-1:0] magic_byte;
  logic             byte_nz;
  logic             bl_hi_all;
  logic             too_big;
  logic             empty_frame;
  logic             left_last;

  assign pos         = cnt_q[2:0];
  assign magic_byte  = cfg_i.frame_magic[{pos, 3'b000} +: ByteW];
  assign byte_nz     = (rx_byte_i != '0);
  assign bl_hi_all   = bl_hi_q || byte_nz;
  assign too_big     = hl_hi_q || (hl_q > cfg_i.header_limit) ||
                       bl_hi_all || (bl_q > cfg_i.body_limit);
  assign empty_frame = (hl_q == '0) && (bl_q == '0);
  assign left_last   = (left_q == LeftW'(1));
  assign phase_o     = phase_q;

  always_comb begin
    phase_d = phase_q;
    if (take_i) begin
      case (phase_q)
        PH_HUNT: begin
          if (cnt_q == MagicEnd && !(bad_q || magic_byte != rx_byte_i)) begin
            phase_d = PH_HLEN;
          end
        end
        PH_HLEN: begin
          if (cnt_q == HlenEnd) begin
            phase_d = PH_BLEN;
          end
        end
        PH_BLEN: begin
          if (cnt_q == PrefixEnd) begin
            phase_d = (too_big || empty_frame) ? PH_HUNT : PH_DATA;
          end
        end
        PH_DATA: begin
          if (left_last) begin
            phase_d = PH_HUNT;
          end
        end
        default: phase_d = PH_HUNT;
      endcase
    end
  end

  always_comb begin
    cnt_d     = cnt_q;
    bad_d     = bad_q;
    hl_hi_d   = hl_hi_q;
    bl_hi_d   = bl_hi_q;
    hl_d      = hl_q;
    bl_d      = bl_q;
    left_d    = left_q;
    res_vld_o = 1'b0;
    res_o     = '{kind: KIND_START, header_len: '0, body_len: '0, data_byte: '0, last: 1'b0};
    if (take_i) begin
      case (phase_q)
        PH_HUNT: begin
          bad_d = bad_q || (magic_byte != rx_byte_i);
          cnt_d = cnt_q + CntW'(1);
          if (cnt_q == MagicEnd && bad_d) begin
            cnt_d      = '0;
            bad_d      = 1'b0;
            res_vld_o  = 1'b1;
            res_o.kind = KIND_BADMAGIC;
          end
        end
        PH_HLEN: begin
          cnt_d = cnt_q + CntW'(1);
          if (!pos[2]) begin
            hl_d[{pos[1:0], 3'b000} +: ByteW] = rx_byte_i;
          end else begin
            hl_hi_d = hl_hi_q || byte_nz;
          end
        end
        PH_BLEN: begin
          cnt_d = cnt_q + CntW'(1);
          if (!pos[2]) begin
            bl_d[{pos[1:0], 3'b000} +: ByteW] = rx_byte_i;
          end else begin
            bl_hi_d = bl_hi_all;
          end
          if (cnt_q == PrefixEnd) begin
            cnt_d     = '0;
            bad_d     = 1'b0;
            hl_hi_d   = 1'b0;
            bl_hi_d   = 1'b0;
            res_vld_o = 1'b1;
            if (too_big) begin
              res_o.kind = KIND_TOOBIG;
            end else if (empty_frame) begin
              res_o.kind = KIND_START;
              res_o.last = 1'b1;
            end else begin
              res_o.kind       = KIND_START;
              res_o.header_len = hl_q;
              res_o.body_len   = bl_q;
              left_d           = {1'b0, hl_q} + {1'b0, bl_q};
            end
          end
        end
        PH_DATA: begin
          left_d          = left_q - LeftW'(1);
          res_vld_o       = 1'b1;
          res_o.kind      = KIND_DATA;
          res_o.data_byte = rx_byte_i;
          res_o.last      = left_last;
        end
        default: cnt_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      cnt_q   <= '0;
      bad_q   <= 1'b0;
      hl_hi_q <= 1'b0;
      bl_hi_q <= 1'b0;
      left_q  <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      bad_q   <= bad_d;
      hl_hi_q <= hl_hi_d;
      bl_hi_q <= bl_hi_d;
      left_q  <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hl_q <= hl_d;
    bl_q <= bl_d;
  end

endmodule

>>> sv/magic_length_packet_deframer.sv
// Top level of the magic-word length-prefixed deframer.
//
// Channel   Direction  Handshake          Payload
// input     in         push / full        rx_byte_i
// result    out        empty / pop        kind_o, header_len_o, body_len_o, data_byte_o, last_o
// config    in         cfg_we_i           cfg_index_i, cfg_data_i
//
// One byte is taken every cycle while full is low; a result is in the
// queue in the cycle after its byte. Full rises only when four results
// wait, set by the depth of the result queue. Reset puts the parser back
// into the magic hunt and empties the queue; no clearing pass is needed.
`include "magic_length_packet_deframer_assert.svh"

module magic_length_packet_deframer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [mlpd_pkg::ByteW-1:0]    rx_byte_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    kind_o,
  output logic [mlpd_pkg::LenW-1:0]     header_len_o,
  output logic [mlpd_pkg::LenW-1:0]     body_len_o,
  output logic [mlpd_pkg::ByteW-1:0]    data_byte_o,
  output logic                          last_o,
  input  logic                          cfg_we_i,
  input  logic [mlpd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mlpd_pkg::MagicW-1:0]   cfg_data_i
);
  import mlpd_pkg::*;

  cfg_t    cfg_q;
  logic    take;
  logic    res_vld;
  res_t    res;
  res_t    head;
  phase_e  phase;
  q_stat_t q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_magic  <= '0;
      cfg_q.header_limit <= HeaderLimitRst;
      cfg_q.body_limit   <= BodyLimitRst;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_FRAME_MAGIC:  cfg_q.frame_magic  <= cfg_data_i;
        REG_HEADER_LIMIT: cfg_q.header_limit <= cfg_data_i[LenW-1:0];
        REG_BODY_LIMIT:   cfg_q.body_limit   <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  assign take = push && !q_stat.full;

  mlpd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .take_i    (take),
    .rx_byte_i (rx_byte_i),
    .res_vld_o (res_vld),
    .res_o     (res),
    .phase_o   (phase)
  );

  mlpd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (res_vld),
    .wr_data_i (res),
    .rd_i      (pop),
    .rd_data_o (head),
    .stat_o    (q_stat)
  );

  assign full         = q_stat.full;
  assign empty        = q_stat.empty;
  assign kind_o       = head.kind;
  assign header_len_o = head.header_len;
  assign body_len_o   = head.body_len;
  assign data_byte_o  = head.data_byte;
  assign last_o       = head.last;

  `MLPD_ASSERT_NEXT(a_result_reaches_queue, res_vld, !empty)
  `MLPD_ASSERT_IMPL(a_data_only_in_payload, res_vld && res.kind == KIND_DATA,
                    phase == PH_DATA)
  `MLPD_ASSERT_NEXT(a_open_frame_enters_payload,
                    res_vld && res.kind == KIND_START && !res.last, phase == PH_DATA)
  `MLPD_ASSERT_IMPL(a_errors_carry_no_payload,
                    !empty && (kind_o == KIND_BADMAGIC || kind_o == KIND_TOOBIG),
                    !last_o && header_len_o == '0 && body_len_o == '0)

endmodule

>>> tb/tb_magic_length_packet_deframer.sv
// Self-checking testbench for the magic-word length-prefixed deframer.
module tb_magic_length_packet_deframer;
  timeunit 1ns;
  timeprecision 1ps;
  import mlpd_pkg::*;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned MaxMsgs    = 40;
  localparam int unsigned Settings   = 8;
  localparam int unsigned BytesPerSetting = 170;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               push        = 1'b0;
  logic               full;
  logic [ByteW-1:0]   rx_byte_i   = '0;
  logic               empty;
  logic               pop         = 1'b0;
  logic [1:0]         kind_o;
  logic [LenW-1:0]    header_len_o;
  logic [LenW-1:0]    body_len_o;
  logic [ByteW-1:0]   data_byte_o;
  logic               last_o;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [MagicW-1:0]  cfg_data_i  = '0;

  magic_length_packet_deframer DUT (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  cfg_t             cfg_now;
  phase_e           ph_now;
  logic [CntW-1:0]  prefix_cnt;
  logic             magic_miss;
  logic [63:0]      hlen_acc;
  logic [63:0]      blen_acc;
  logic [LeftW-1:0] payload_left;

  logic [ByteW-1:0] rx_stream_q[$];
  res_t             deframed_q[$];

  int unsigned errors = 0;
  int unsigned bytes_in = 0;
  int unsigned results_out = 0;
  int unsigned n_start = 0;
  int unsigned n_empty = 0;
  int unsigned n_payload = 0;
  int unsigned n_badmagic = 0;
  int unsigned n_toobig = 0;

  function automatic void rearm_search();
    ph_now       = PH_HUNT;
    prefix_cnt   = '0;
    magic_miss   = 1'b0;
    hlen_acc     = '0;
    blen_acc     = '0;
    payload_left = '0;
  endfunction

  // Returns 1 when the byte produces a result, which is then placed in r.
  function automatic bit deframe_byte(input logic [ByteW-1:0] b, output res_t r);
    int sh;
    logic [CntW-1:0] at;
    r = '0;
    if (ph_now == PH_DATA) begin
      payload_left = payload_left - 1'b1;
      r.kind      = KIND_DATA;
      r.data_byte = b;
      r.last      = (payload_left == '0);
      if (r.last) rearm_search();
      return 1'b1;
    end
    sh = 8 * int'(prefix_cnt[2:0]);
    case (ph_now)
      PH_HUNT: if (cfg_now.frame_magic[sh +: 8] != b) magic_miss = 1'b1;
      PH_HLEN: hlen_acc[sh +: 8] = b;
      default: blen_acc[sh +: 8] = b;
    endcase
    at = prefix_cnt;
    prefix_cnt = prefix_cnt + 1'b1;
    if (ph_now == PH_HUNT && at == MagicEnd) begin
      if (magic_miss) begin
        rearm_search();
        r.kind = KIND_BADMAGIC;
        return 1'b1;
      end
      ph_now = PH_HLEN;
    end else if (at == HlenEnd) begin
      ph_now = PH_BLEN;
    end else if (at == PrefixEnd) begin
      if (hlen_acc > 64'(cfg_now.header_limit) || blen_acc > 64'(cfg_now.body_limit)) begin
        rearm_search();
        r.kind = KIND_TOOBIG;
        return 1'b1;
      end
      r.kind = KIND_START;
      if (hlen_acc == '0 && blen_acc == '0) begin
        rearm_search();
        r.last = 1'b1;
        return 1'b1;
      end
      r.header_len = hlen_acc[LenW-1:0];
      r.body_len   = blen_acc[LenW-1:0];
      ph_now       = PH_DATA;
      prefix_cnt   = '0;
      magic_miss   = 1'b0;
      payload_left = LeftW'(hlen_acc) + LeftW'(blen_acc);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void report(string field, logic [63:0] want, logic [63:0] got);
    errors++;
    if (errors <= MaxMsgs)
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
  endfunction

  function automatic void push_le64(logic [63:0] v);
    for (int i = 0; i < 8; i++) rx_stream_q.push_back(v[8*i +: 8]);
  endfunction

  function automatic void add_frame(logic [63:0] hl, logic [63:0] bl);
    push_le64(cfg_now.frame_magic);
    push_le64(hl);
    push_le64(bl);
    if (hl <= 64'(cfg_now.header_limit) && bl <= 64'(cfg_now.body_limit))
      repeat (int'(hl + bl)) rx_stream_q.push_back(ByteW'($urandom));
  endfunction

  function automatic void add_bad_magic(int pos);
    logic [63:0] m;
    m = cfg_now.frame_magic;
    m[8*pos +: 8] = m[8*pos +: 8] ^ ByteW'($urandom_range(1, 255));
    push_le64(m);
  endfunction

  function automatic logic [63:0] fit_len(logic [LenW-1:0] lim);
    int unsigned n;
    n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
    return (n > lim) ? 64'(lim) : 64'(n);
  endfunction

  function automatic logic [63:0] over_len(logic [LenW-1:0] lim);
    case ($urandom_range(0, 2))
      0: return 64'(lim) + 64'd1;
      1: return 64'(lim) + 64'($urandom_range(2, 1000));
      default: return {$urandom_range(1, 32'hFFFF_FFFF), $urandom};
    endcase
  endfunction

  function automatic void add_unit();
    logic [63:0] m;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5:
        add_frame(fit_len(cfg_now.header_limit), fit_len(cfg_now.body_limit));
      6: begin
        if ($urandom_range(0, 1) == 0)
          add_frame(over_len(cfg_now.header_limit), fit_len(cfg_now.body_limit));
        else
          add_frame(fit_len(cfg_now.header_limit), over_len(cfg_now.body_limit));
      end
      7: add_bad_magic($urandom_range(0, 7));
      8: begin
        m = {$urandom, $urandom};
        if (m == cfg_now.frame_magic) m[0] = ~m[0];
        push_le64(m);
      end
      default: add_frame('0, '0);
    endcase
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [MagicW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_FRAME_MAGIC:  cfg_now.frame_magic  = value;
      REG_HEADER_LIMIT: cfg_now.header_limit = value[LenW-1:0];
      REG_BODY_LIMIT:   cfg_now.body_limit   = value[LenW-1:0];
      default: ;
    endcase
  endtask

  // The sender holds off until every queued byte is taken and every result is back.
  task automatic settle();
    do @(negedge clk_i);
    while (rx_stream_q.size() != 0 || push || !empty || deframed_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin
    res_t r;
    if (push && !full) begin
      bytes_in++;
      if (deframe_byte(rx_byte_i, r)) deframed_q.push_back(r);
    end
    if (!push || !full) begin
      if (gap_left != 0) begin
        gap_left--;
        push      <= 1'b0;
        rx_byte_i <= ByteW'($urandom);
      end else if (rx_stream_q.size() != 0) begin
        push      <= 1'b1;
        rx_byte_i <= rx_stream_q.pop_front();
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  logic [15:0] pop_pattern = 16'hFFFF;
  int unsigned pattern_age = 0;

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && pop && !empty) begin
      results_out++;
      if (deframed_q.size() == 0) begin
        errors++;
        if (errors <= MaxMsgs)
          $display("%0t: result of kind %0d arrived with none expected", $time, kind_o);
      end else begin
        want = deframed_q.pop_front();
        if (kind_o !== want.kind) report("kind", want.kind, kind_o);
        if (header_len_o !== want.header_len) report("header_len", want.header_len, header_len_o);
        if (body_len_o !== want.body_len) report("body_len", want.body_len, body_len_o);
        if (data_byte_o !== want.data_byte) report("data_byte", want.data_byte, data_byte_o);
        if (last_o !== want.last) report("last", want.last, last_o);
        case (want.kind)
          KIND_START: begin
            n_start++;
            if (want.last) n_empty++;
          end
          KIND_DATA:     n_payload++;
          KIND_BADMAGIC: n_badmagic++;
          default:       n_toobig++;
        endcase
      end
    end
    if (pattern_age == 0) begin
      pattern_age = 64;
      case ($urandom_range(0, 3))
        0: pop_pattern = 16'hFFFF;
        1: pop_pattern = 16'($urandom) | 16'h0001;
        2: pop_pattern = 16'h0001 << $urandom_range(0, 15);
        default: pop_pattern = 16'($urandom) | 16'h8001;
      endcase
    end
    pattern_age--;
    pop <= pop_pattern[0];
    pop_pattern = {pop_pattern[0], pop_pattern[15:1]};
  end

  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, StallLimit, deframed_q.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [MagicW-1:0] m;
    logic [LenW-1:0]   hl;
    logic [LenW-1:0]   bl;
    cfg_now = '{frame_magic: '0, header_limit: HeaderLimitRst, body_limit: BodyLimitRst};
    rearm_search();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_frame('0, '0);
    add_frame(64'd1, '0);
    add_frame('0, 64'd1);
    add_frame(64'd3, 64'd2);
    push_le64(cfg_now.frame_magic);
    push_le64('0);
    push_le64(64'd2);
    rx_stream_q.push_back(8'h00);
    rx_stream_q.push_back(8'hFF);
    add_bad_magic(0);
    add_bad_magic(7);
    add_frame(64'(HeaderLimitRst) + 64'd1, '0);
    add_frame('0, 64'(BodyLimitRst) + 64'd1);
    add_frame(64'h1_0000_0000, '0);
    add_frame('0, '1);
    add_frame(64'd2, 64'd1);
    settle();

    write_reg(REG_FRAME_MAGIC, '1);
    write_reg(REG_HEADER_LIMIT, {32'hA5A5_5A5A, 32'd3});
    write_reg(REG_BODY_LIMIT, {32'hFFFF_FFFF, 32'd4});
    write_reg(REG_UNUSED, {$urandom, $urandom});
    add_frame(64'd3, 64'd4);
    add_frame(64'd4, '0);
    add_frame('0, 64'd5);
    add_bad_magic(3);
    add_frame('0, '0);
    settle();

    for (int s = 0; s < Settings; s++) begin
      m  = {$urandom, $urandom};
      hl = HeaderLimitRst;
      bl = BodyLimitRst;
      case (s)
        1: begin
          m  = '1;
          hl = '0;
          bl = '0;
        end
        2: begin
          hl = '1;
          bl = '1;
        end
        3: begin
          m  = '0;
          hl = $urandom_range(0, 12);
          bl = $urandom_range(0, 12);
        end
        4: begin
          hl = $urandom_range(0, 6);
          bl = '1;
        end
        5: begin
          hl = $urandom;
          bl = $urandom;
        end
        6: begin
          hl = '1;
          bl = $urandom_range(0, 3);
        end
        default: ;
      endcase
      write_reg(REG_UNUSED, {$urandom, $urandom});
      write_reg(REG_FRAME_MAGIC, m);
      write_reg(REG_HEADER_LIMIT, {$urandom, hl});
      write_reg(REG_BODY_LIMIT, {$urandom, bl});
      while (rx_stream_q.size() < BytesPerSetting) add_unit();
      settle();
    end

    repeat (40) @(posedge clk_i);
    $display("Fed %0d bytes over %0d magic and limit settings; checked %0d results.",
             bytes_in, Settings + 2, results_out);
    $display("Frames started %0d (%0d empty), payload bytes %0d, bad magic %0d, oversize %0d.",
             n_start, n_empty, n_payload, n_badmagic, n_toobig);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/mlpd_pkg.sv
sv/mlpd_fifo.sv
sv/mlpd_front.sv
sv/magic_length_packet_deframer.sv
tb/tb_magic_length_packet_deframer.sv
